// ===== design/lpe_pkg.sv =====
// Shared constants for the Lomuto partition engine.
package lpe_pkg;

  localparam int unsigned LPE_MAX_ELEMENTS = 64;
  localparam int unsigned LPE_ELEMENT_BITS = 32;
  localparam int unsigned LPE_VALUE_BITS   = 32;
  localparam int unsigned LPE_PIDX_BITS    = 6;
  localparam int unsigned LPE_ADDR_BITS    = 3;
  localparam int unsigned LPE_DATA_BITS    = 32;

  localparam logic LPE_REG_COMPARE_SIGNED = 1'b0;

endpackage

// ===== design/lpe_cmp.sv =====
// Order compare: signed or unsigned less-or-equal of an element against the pivot.
module lpe_cmp #(
  parameter int unsigned ELEMENT_BITS = lpe_pkg::LPE_ELEMENT_BITS
) (
  input  logic [ELEMENT_BITS-1:0] elem_i,
  input  logic [ELEMENT_BITS-1:0] pivot_i,
  input  logic                    signed_i,
  output logic                    le_o
);
  import lpe_pkg::*;

  logic [ELEMENT_BITS-1:0] flip;
  logic [ELEMENT_BITS-1:0] elem_key;
  logic [ELEMENT_BITS-1:0] pivot_key;

  always_comb begin
    flip = '0;
    flip[ELEMENT_BITS-1] = signed_i;
  end

  assign elem_key  = elem_i ^ flip;
  assign pivot_key = pivot_i ^ flip;
  assign le_o      = (elem_key <= pivot_key);

endmodule

// ===== design/lomuto_partition_engine.sv =====
// Lomuto partition engine top level: element store, sequencer, APB register.
//
// Elements load one per cycle while busy is low. The element marked last starts the
// partition: busy rises and stays high until the cycle that shows the final result, and that
// cycle can already take the next element. The partition fetches the pivot (S_PIV_RD, S_PIV_LD),
// reads and compares each scanned element (S_SCAN_RD, S_SCAN_CMP), with the further state
// S_SCAN_SWP when an element must be swapped behind the boundary, and places the pivot
// (S_FIN_RD, S_FIN_W1, S_FIN_W2). The output pass then reads one element per cycle and shows
// each result in the cycle after its read, n results on consecutive cycles for n stored
// elements. The element store has two read ports and a single write port, so a swap is two
// separate writes. Results cannot be stalled: each is shown for exactly one cycle with result_valid_o high.
module lomuto_partition_engine #(
  parameter int unsigned MAX_ELEMENTS = lpe_pkg::LPE_MAX_ELEMENTS,
  parameter int unsigned ELEMENT_BITS = lpe_pkg::LPE_ELEMENT_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [lpe_pkg::LPE_VALUE_BITS-1:0]   element_value_i,
  input  logic                                 is_last_i,
  output logic                                 result_valid_o,
  output logic [lpe_pkg::LPE_VALUE_BITS-1:0]   out_value_o,
  output logic [lpe_pkg::LPE_PIDX_BITS-1:0]    pivot_index_o,
  output logic                                 overflowed_o,
  output logic                                 out_last_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lpe_pkg::LPE_ADDR_BITS-1:0]    paddr,
  input  logic [lpe_pkg::LPE_DATA_BITS-1:0]    pwdata,
  output logic [lpe_pkg::LPE_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);
  import lpe_pkg::*;

  localparam int unsigned IDX_W   = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned EXT_W   = (ELEMENT_BITS > LPE_VALUE_BITS) ? ELEMENT_BITS
                                                                    : LPE_VALUE_BITS;
  localparam int unsigned PEXT_W  = (IDX_W > LPE_PIDX_BITS) ? IDX_W : LPE_PIDX_BITS;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PIV_RD   = 4'd1;
  localparam logic [3:0] S_PIV_LD   = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CMP = 4'd4;
  localparam logic [3:0] S_SCAN_SWP = 4'd5;
  localparam logic [3:0] S_FIN_RD   = 4'd6;
  localparam logic [3:0] S_FIN_W1   = 4'd7;
  localparam logic [3:0] S_FIN_W2   = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  logic [ELEMENT_BITS-1:0] mem_q [MAX_ELEMENTS];
  logic [ELEMENT_BITS-1:0] rdata_a_q, rdata_b_q;
  logic [IDX_W-1:0]        raddr_a, raddr_b, waddr;
  logic [ELEMENT_BITS-1:0] wdata;
  logic                    we;

  logic [3:0]              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [IDX_W-1:0]        scan_q, scan_d;
  logic [IDX_W-1:0]        bnd_q, bnd_d;
  logic [IDX_W-1:0]        k_q, k_d;
  logic                    ovf_q, ovf_d;
  logic [ELEMENT_BITS-1:0] piv_q, piv_d;
  logic                    cs_q;

  logic                    strobe_q, strobe_d;
  logic                    last_q, last_d;
  logic [LPE_PIDX_BITS-1:0] pidx_q, pidx_d;
  logic                    ovf_out_q, ovf_out_d;

  logic [IDX_W-1:0]        pv;
  logic                    le;
  logic                    accept;
  logic [EXT_W-1:0]        din_ext;
  logic [EXT_W-1:0]        dout_ext;
  logic [PEXT_W-1:0]       bnd_ext;
  logic                    cfg_wr;
  logic                    scan_end;

  assign pv       = IDX_W'(cnt_q - CNT_W'(1));
  assign accept   = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);
  assign din_ext  = EXT_W'(element_value_i);
  assign dout_ext = EXT_W'(rdata_a_q);
  assign bnd_ext  = PEXT_W'(bnd_q);
  assign scan_end = (scan_q == IDX_W'(pv - IDX_W'(1)));

  lpe_cmp #(
    .ELEMENT_BITS(ELEMENT_BITS)
  ) u_cmp (
    .elem_i  (rdata_a_q),
    .pivot_i (piv_q),
    .signed_i(cs_q),
    .le_o    (le)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    scan_d    = scan_q;
    bnd_d     = bnd_q;
    k_d       = k_q;
    ovf_d     = ovf_q;
    piv_d     = piv_q;
    strobe_d  = 1'b0;
    last_d    = 1'b0;
    pidx_d    = pidx_q;
    ovf_out_d = ovf_out_q;
    raddr_a   = k_q;
    raddr_b   = bnd_q;
    waddr     = bnd_q;
    wdata     = rdata_a_q;
    we        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cnt_q < CNT_W'(MAX_ELEMENTS)) begin
            we    = 1'b1;
            waddr = cnt_q[IDX_W-1:0];
            wdata = din_ext[ELEMENT_BITS-1:0];
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (is_last_i) begin
            state_d = S_PIV_RD;
          end
        end
      end
      S_PIV_RD: begin
        raddr_a = pv;
        state_d = S_PIV_LD;
      end
      S_PIV_LD: begin
        piv_d  = rdata_a_q;
        scan_d = '0;
        bnd_d  = '0;
        state_d = (pv == '0) ? S_FIN_RD : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        raddr_a = scan_q;
        raddr_b = bnd_q;
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (le && (scan_q != bnd_q)) begin
          we      = 1'b1;
          waddr   = bnd_q;
          wdata   = rdata_a_q;
          state_d = S_SCAN_SWP;
        end else begin
          if (le) begin
            bnd_d = bnd_q + IDX_W'(1);
          end
          scan_d  = scan_q + IDX_W'(1);
          state_d = scan_end ? S_FIN_RD : S_SCAN_RD;
        end
      end
      S_SCAN_SWP: begin
        we      = 1'b1;
        waddr   = scan_q;
        wdata   = rdata_b_q;
        bnd_d   = bnd_q + IDX_W'(1);
        scan_d  = scan_q + IDX_W'(1);
        state_d = scan_end ? S_FIN_RD : S_SCAN_RD;
      end
      S_FIN_RD: begin
        raddr_a = pv;
        raddr_b = bnd_q;
        state_d = S_FIN_W1;
      end
      S_FIN_W1: begin
        we      = 1'b1;
        waddr   = bnd_q;
        wdata   = rdata_a_q;
        state_d = S_FIN_W2;
      end
      S_FIN_W2: begin
        we      = 1'b1;
        waddr   = pv;
        wdata   = rdata_b_q;
        k_d     = '0;
        state_d = S_OUT;
      end
      S_OUT: begin
        raddr_a   = k_q;
        strobe_d  = 1'b1;
        last_d    = (k_q == pv);
        pidx_d    = bnd_ext[LPE_PIDX_BITS-1:0];
        ovf_out_d = ovf_q;
        k_d       = k_q + IDX_W'(1);
        if (k_q == pv) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          bnd_d   = '0;
          scan_d  = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_a_q <= mem_q[raddr_a];
    rdata_b_q <= mem_q[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      scan_q    <= '0;
      bnd_q     <= '0;
      k_q       <= '0;
      ovf_q     <= 1'b0;
      strobe_q  <= 1'b0;
      last_q    <= 1'b0;
      pidx_q    <= '0;
      ovf_out_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      scan_q    <= scan_d;
      bnd_q     <= bnd_d;
      k_q       <= k_d;
      ovf_q     <= ovf_d;
      strobe_q  <= strobe_d;
      last_q    <= last_d;
      pidx_q    <= pidx_d;
      ovf_out_q <= ovf_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    piv_q <= piv_d;
  end

  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr[LPE_ADDR_BITS-1] == LPE_REG_COMPARE_SIGNED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q <= 1'b0;
    end else if (cfg_wr) begin
      cs_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[LPE_ADDR_BITS-1] == LPE_REG_COMPARE_SIGNED)
                ? LPE_DATA_BITS'(cs_q) : '0;

  assign result_valid_o = strobe_q;
  assign out_value_o    = dout_ext[LPE_VALUE_BITS-1:0];
  assign pivot_index_o  = pidx_q;
  assign overflowed_o   = ovf_out_q;
  assign out_last_o     = last_q;

endmodule

// ===== design/lpe_checker.sv =====
// Port-level checks for the Lomuto partition engine, bound to the top level.
module lpe_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               is_last_i,
  input logic                               result_valid_o,
  input logic                               out_last_o,
  input logic [lpe_pkg::LPE_PIDX_BITS-1:0]  pivot_index_o,
  input logic                               overflowed_o
);
  import lpe_pkg::*;

  a_plain_element_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !is_last_i) |=> !busy)
    else $error("busy after an element that is not last");

  a_last_element_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && is_last_i) |=> busy)
    else $error("no partition after the last element");

  a_results_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !out_last_o) |=> result_valid_o)
    else $error("gap inside a result burst");

  a_busy_during_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !out_last_o) |-> busy)
    else $error("accepting input in the middle of a result burst");

  a_burst_fields_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !out_last_o) |=>
      ($stable(pivot_index_o) && $stable(overflowed_o)))
    else $error("pivot index or overflow changed inside a burst");

endmodule

bind lomuto_partition_engine lpe_checker u_lpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .is_last_i     (is_last_i),
  .result_valid_o(result_valid_o),
  .out_last_o    (out_last_o),
  .pivot_index_o (pivot_index_o),
  .overflowed_o  (overflowed_o)
);

// ===== bench/lpe_partition_check_pkg.sv =====
// Expected-result predictor and scoreboard for the Lomuto partition engine testbench.
package lpe_partition_check_pkg;

  import lpe_pkg::*;

  typedef struct packed {
    logic [LPE_VALUE_BITS-1:0] value;
    logic [LPE_PIDX_BITS-1:0]  pivot;
    logic                      ovf;
    logic                      last;
  } part_result_t;

  class partition_scoreboard;
    logic [LPE_ELEMENT_BITS-1:0] store [LPE_MAX_ELEMENTS];
    int unsigned                 loaded;
    bit                          dropped;
    bit                          signed_order;
    int unsigned                 mismatches;
    part_result_t                partitioned_q [$];

    function new();
      loaded       = 0;
      dropped      = 0;
      signed_order = 0;
      mismatches   = 0;
    endfunction

    function logic [LPE_ELEMENT_BITS-1:0] order_key(logic [LPE_ELEMENT_BITS-1:0] v);
      return signed_order ? (v ^ (1 << (LPE_ELEMENT_BITS - 1))) : v;
    endfunction

    function void note_element(logic [LPE_VALUE_BITS-1:0] value, logic last);
      logic [LPE_ELEMENT_BITS-1:0] pivot_key;
      logic [LPE_ELEMENT_BITS-1:0] held;
      int unsigned                 pv;
      int unsigned                 bound;
      part_result_t                r;
      if (loaded < LPE_MAX_ELEMENTS) begin
        store[loaded] = value;
        loaded++;
      end else begin
        dropped = 1;
      end
      if (!last || loaded == 0) return;
      pv        = loaded - 1;
      pivot_key = order_key(store[pv]);
      bound     = 0;
      for (int unsigned s = 0; s < pv; s++) begin
        if (order_key(store[s]) <= pivot_key) begin
          held         = store[bound];
          store[bound] = store[s];
          store[s]     = held;
          bound++;
        end
      end
      held         = store[pv];
      store[pv]    = store[bound];
      store[bound] = held;
      for (int unsigned k = 0; k < loaded; k++) begin
        r.value = store[k];
        r.pivot = LPE_PIDX_BITS'(bound);
        r.ovf   = dropped;
        r.last  = (k + 1 == loaded);
        partitioned_q.push_back(r);
      end
      loaded  = 0;
      dropped = 0;
    endfunction

    function void check_output(part_result_t got);
      part_result_t exp;
      if (partitioned_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual value %h pivot %0d ovf %0b last %0b",
                 $time, got.value, got.pivot, got.ovf, got.last);
        return;
      end
      exp = partitioned_q.pop_front();
      if (got.value !== exp.value) begin
        mismatches++;
        $display("%0t: out_value expected %h actual %h", $time, exp.value, got.value);
      end
      if (got.pivot !== exp.pivot) begin
        mismatches++;
        $display("%0t: pivot_index expected %0d actual %0d", $time, exp.pivot, got.pivot);
      end
      if (got.ovf !== exp.ovf) begin
        mismatches++;
        $display("%0t: overflowed expected %0b actual %0b", $time, exp.ovf, got.ovf);
      end
      if (got.last !== exp.last) begin
        mismatches++;
        $display("%0t: out_last expected %0b actual %0b", $time, exp.last, got.last);
      end
    endfunction
  endclass

endpackage

// ===== bench/lomuto_partition_engine_test.sv =====
// Top-level testbench for the Lomuto partition engine: stimulus, APB access and checking.
module lomuto_partition_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpe_pkg::*;
  import lpe_partition_check_pkg::*;

  localparam int unsigned ITEM_TARGET   = 430;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned UNUSED_REG    = 1;
  localparam logic [LPE_ADDR_BITS-1:0] ORDER_ADDR  =
    LPE_ADDR_BITS'(4 * int'(LPE_REG_COMPARE_SIGNED));
  localparam logic [LPE_ADDR_BITS-1:0] UNUSED_ADDR = LPE_ADDR_BITS'(4 * UNUSED_REG);

  localparam int VALUES_RANDOM  = 0;
  localparam int VALUES_NEAR0   = 1;
  localparam int VALUES_EXTREME = 2;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [LPE_VALUE_BITS-1:0] element_value_i;
  logic                      is_last_i;
  logic                      result_valid_o;
  logic [LPE_VALUE_BITS-1:0] out_value_o;
  logic [LPE_PIDX_BITS-1:0]  pivot_index_o;
  logic                      overflowed_o;
  logic                      out_last_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [LPE_ADDR_BITS-1:0]  paddr;
  logic [LPE_DATA_BITS-1:0]  pwdata;
  logic [LPE_DATA_BITS-1:0]  prdata;
  logic                      pready;

  partition_scoreboard       sb;
  int unsigned               idle_cycles;
  int unsigned               items_sent;
  logic [LPE_VALUE_BITS-1:0] pattern [$];

  lomuto_partition_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .element_value_i(element_value_i),
    .is_last_i      (is_last_i),
    .result_valid_o (result_valid_o),
    .out_value_o    (out_value_o),
    .pivot_index_o  (pivot_index_o),
    .overflowed_o   (overflowed_o),
    .out_last_o     (out_last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        sb.check_output(part_result_t'({out_value_o, pivot_index_o, overflowed_o, out_last_o}));
      end
      if ((start && !busy) || result_valid_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_element(input logic [LPE_VALUE_BITS-1:0] value, input logic last,
                              input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    element_value_i <= value;
    is_last_i       <= last;
    do @(posedge clk_i); while (busy);
    sb.note_element(value, last);
    items_sent++;
  endtask

  task automatic send_pattern();
    for (int i = 0; i < pattern.size(); i++) begin
      send_element(pattern[i], i == pattern.size() - 1, $urandom_range(0, 3));
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.partitioned_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write, input logic [LPE_ADDR_BITS-1:0] addr,
                            input logic [LPE_DATA_BITS-1:0] data,
                            output logic [LPE_DATA_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (write && addr == ORDER_ADDR) sb.signed_order = data[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_order(input bit signed_mode, input bit touch_unused);
    logic [LPE_DATA_BITS-1:0] rdata;
    drain_results();
    if (touch_unused) apb_access(1'b1, UNUSED_ADDR, $urandom(), rdata);
    apb_access(1'b1, ORDER_ADDR, {$urandom()} & ~32'h1 | signed_mode, rdata);
    apb_access(1'b0, ORDER_ADDR, '0, rdata);
    if (rdata[0] !== signed_mode) begin
      sb.mismatches++;
      $display("%0t: compare_signed read expected %0b actual %0b", $time, signed_mode, rdata[0]);
    end
  endtask

  function automatic logic [LPE_VALUE_BITS-1:0] next_value(int kind);
    logic [LPE_VALUE_BITS-1:0] v;
    case (kind)
      VALUES_NEAR0: begin
        v = $urandom_range(0, 3);
        if ($urandom_range(0, 1)) v = ~v;
      end
      VALUES_EXTREME: begin
        case ($urandom_range(0, 5))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'h7FFF_FFFF;
          3: v = 32'h8000_0000;
          4: v = 32'hFFFF_FFFF;
          default: v = $urandom();
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  initial begin
    int unsigned len;
    int unsigned arrays;
    int          kind;
    bit          no_gaps;
    start           <= 1'b0;
    element_value_i <= '0;
    is_last_i       <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    idle_cycles     = 0;
    items_sent      = 0;
    arrays          = 0;
    sb              = new();
    rst_ni          = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pattern = '{32'hFFFF_FFFF};
    send_pattern();
    pattern = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h8000_0000};
    send_pattern();
    pattern = '{32'h5, 32'h5, 32'h5};
    send_pattern();
    set_order(1'b1, 1'b1);
    pattern = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF};
    send_pattern();
    pattern = '{32'h8000_0000, 32'h7FFF_FFFF};
    send_pattern();
    set_order(1'b0, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) set_order($urandom_range(0, 1), $urandom_range(0, 4) == 0);
      case (arrays)
        0: len = LPE_MAX_ELEMENTS + 2;
        1: len = LPE_MAX_ELEMENTS;
        default: begin
          case ($urandom_range(0, 19))
            0: len = $urandom_range(LPE_MAX_ELEMENTS, LPE_MAX_ELEMENTS + 3);
            1: len = $urandom_range(13, LPE_MAX_ELEMENTS - 1);
            default: len = $urandom_range(1, 12);
          endcase
        end
      endcase
      kind    = $urandom_range(VALUES_RANDOM, VALUES_EXTREME);
      no_gaps = ($urandom_range(0, 2) == 0);
      for (int unsigned i = 0; i < len; i++) begin
        send_element(next_value(kind), i == len - 1, no_gaps ? 0 : $urandom_range(0, 15));
      end
      arrays++;
    end

    drain_results();
    if (sb.mismatches == 0 && sb.partitioned_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/lpe_pkg.sv
design/lpe_cmp.sv
design/lomuto_partition_engine.sv
design/lpe_checker.sv
bench/lpe_partition_check_pkg.sv
bench/lomuto_partition_engine_test.sv
